>>> rtl/alaa_pkg.sv
`timescale 1ns / 1ps

package alaa_pkg;

  localparam int unsigned ANGLE_W    = 32;
  localparam int unsigned ACCEL_W    = 31;
  localparam int unsigned TICK_W     = 16;
  localparam int unsigned SNAP_W     = 16;
  localparam int unsigned AXES       = 3;
  localparam int unsigned AXIS_W     = $clog2(AXES);
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = ACCEL_W;
  localparam int unsigned DIVD_W     = 2 * ANGLE_W;
  localparam int unsigned DIVS_W     = ACCEL_W + 1;

  localparam logic [ACCEL_W-1:0] MAX_ACCEL_RST = ACCEL_W'(65536);
  localparam logic [TICK_W-1:0]  TICK_RST      = TICK_W'(328);
  localparam logic [SNAP_W-1:0]  SNAP_RST      = SNAP_W'(7);

  localparam logic signed [ANGLE_W-1:0] ANGLE_MAX = {1'b0, {(ANGLE_W - 1){1'b1}}};
  localparam logic signed [ANGLE_W-1:0] ANGLE_MIN = {1'b1, {(ANGLE_W - 1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_ACCEL      = 2'd0,
    CFG_TICK_PERIOD    = 2'd1,
    CFG_SNAP_THRESHOLD = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    DIV_STOP = 1'b0,
    DIV_SNAP = 1'b1
  } div_op_e;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] target_x;
    logic signed [ANGLE_W-1:0] target_y;
    logic signed [ANGLE_W-1:0] target_z;
  } target_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0] angle_x;
    logic signed [ANGLE_W-1:0] angle_y;
    logic signed [ANGLE_W-1:0] angle_z;
    logic signed [ANGLE_W-1:0] rate_x;
    logic signed [ANGLE_W-1:0] rate_y;
    logic signed [ANGLE_W-1:0] rate_z;
  } result_t;

  typedef struct packed {
    logic              load;
    logic              prod;
    logic              div_start;
    div_op_e           div_sel;
    logic              dir;
    logic              vel;
    logic              lin;
    logic              ch;
    logic              dec;
    logic              rate_wr;
    logic              res_load;
    logic [AXIS_W-1:0] axis;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic need_div;
  } status_t;

endpackage

>>> rtl/alaa_stream_if.sv
`timescale 1ns / 1ps

interface alaa_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/alaa_div.sv
`timescale 1ns / 1ps

module alaa_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [alaa_pkg::DIVD_W-1:0] dividend_i,
  input  logic [alaa_pkg::DIVS_W-1:0] divisor_i,
  output logic [alaa_pkg::DIVD_W-1:0] quotient_o,
  output logic                        done_o
);
  import alaa_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVD_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVD_W - 1);

  logic [DIVS_W-1:0] rem_q, rem_d;
  logic [DIVS_W-1:0] divisor_q;
  logic [DIVD_W-1:0] quo_q, quo_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DIVS_W:0]   part;
  logic [DIVS_W:0]   trial;
  logic              ge;
  logic              last;

  always_comb begin
    part  = {rem_q, quo_q[DIVD_W-1]};
    trial = part - {1'b0, divisor_q};
    ge    = ~trial[DIVS_W];
    rem_d = ge ? trial[DIVS_W-1:0] : part[DIVS_W-1:0];
    quo_d = {quo_q[DIVD_W-2:0], ge};
    last  = (cnt_q == CNT_LAST);
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + CNT_W'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q     <= '0;
      quo_q     <= dividend_i;
      divisor_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

endmodule

>>> rtl/alaa_datapath.sv
`timescale 1ns / 1ps

module alaa_datapath #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [alaa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [alaa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  alaa_pkg::target_t               tgt_i,
  input  alaa_pkg::cmd_t                  cmd_i,
  output alaa_pkg::status_t               st_o,
  output alaa_pkg::result_t               res_o
);
  import alaa_pkg::*;

  localparam int unsigned F      = FRACTION_BITS;
  localparam int unsigned AD_W   = ACCEL_W + TICK_W;
  localparam int unsigned QP_W   = AD_W + TICK_W;
  localparam int unsigned DV_W   = AD_W - F;
  localparam int unsigned QUAD_W = QP_W - 2 * F - 1;
  localparam int unsigned OFF_W  = ANGLE_W + 1;
  localparam int unsigned LINP_W = ANGLE_W + TICK_W;
  localparam int unsigned LIN_W  = LINP_W - F;
  localparam int unsigned CH_W   = ((LIN_W > QUAD_W) ? LIN_W : QUAD_W) + 2;
  localparam int unsigned VS_W   = (((DV_W + 1) > ANGLE_W) ? (DV_W + 1) : ANGLE_W) + 1;
  localparam int unsigned PS_W   = ((CH_W > ANGLE_W) ? CH_W : ANGLE_W) + 1;
  localparam int unsigned SO_W   = DIVD_W + 1;
  localparam int unsigned CMP_W  = (CH_W > OFF_W) ? CH_W : OFF_W;
  localparam int unsigned SAT_W  = (VS_W > PS_W) ? VS_W : PS_W;

  function automatic logic signed [ANGLE_W-1:0] sat_angle(input logic signed [SAT_W-1:0] x);
    logic [SAT_W-ANGLE_W:0] top;
    top = x[SAT_W-1:ANGLE_W-1];
    if (top == '0 || top == '1) begin
      sat_angle = x[ANGLE_W-1:0];
    end else if (x[SAT_W-1]) begin
      sat_angle = ANGLE_MIN;
    end else begin
      sat_angle = ANGLE_MAX;
    end
  endfunction

  logic [ACCEL_W-1:0]        max_accel_q;
  logic [TICK_W-1:0]         tick_q;
  logic [SNAP_W-1:0]         snap_thr_q;
  logic signed [ANGLE_W-1:0] angle_q [AXES];
  logic signed [ANGLE_W-1:0] rate_q [AXES];
  logic signed [ANGLE_W-1:0] tgt_q [AXES];
  logic [AD_W-1:0]           ad_q;
  logic [DV_W-1:0]           dv_q;
  logic [QUAD_W-1:0]         quad_q;
  logic                      s_pos_q;
  logic                      s_neg_q;
  logic signed [ANGLE_W-1:0] vn_q;
  logic [LIN_W-1:0]          lin_q;
  logic signed [CH_W-1:0]    ch_q;
  logic                      off_neg_q;
  result_t                   res_q;

  logic signed [ANGLE_W-1:0] pos;
  logic signed [ANGLE_W-1:0] vel;
  logic signed [ANGLE_W-1:0] tgt;
  logic signed [OFF_W-1:0]   off;
  logic [OFF_W-1:0]          om;
  logic [ANGLE_W-1:0]        vm;
  logic [ACCEL_W-1:0]        a_eff;
  logic [DIVD_W-1:0]         sq;
  logic [DIVD_W-1:0]         div_dividend;
  logic [DIVS_W-1:0]         div_divisor;
  logic [DIVD_W-1:0]         quo;
  logic                      div_done;
  logic [QP_W-1:0]           quadp;
  logic signed [SO_W-1:0]    stop_s;
  logic signed [SO_W-1:0]    so;
  logic signed [VS_W-1:0]    dv_s;
  logic signed [VS_W-1:0]    vs;
  logic [ANGLE_W-1:0]        vnm;
  logic [LINP_W-1:0]         linp;
  logic signed [CH_W-1:0]    lin_s;
  logic signed [CH_W-1:0]    quad_s;
  logic [CH_W-1:0]           chm;
  logic                      over;
  logic                      off_zero;
  logic                      snap;
  logic                      need_div;
  logic signed [PS_W-1:0]    ps;
  logic signed [ANGLE_W-1:0] new_pos;
  logic signed [ANGLE_W-1:0] dec_rate;
  logic signed [ANGLE_W-1:0] snap_rate;

  always_comb begin
    pos   = angle_q[cmd_i.axis];
    vel   = rate_q[cmd_i.axis];
    tgt   = tgt_q[cmd_i.axis];
    off   = $signed({tgt[ANGLE_W-1], tgt}) - $signed({pos[ANGLE_W-1], pos});
    om    = off[OFF_W-1] ? OFF_W'(-off) : OFF_W'(off);
    vm    = vel[ANGLE_W-1] ? ANGLE_W'(-vel) : ANGLE_W'(vel);
    a_eff = (max_accel_q == '0) ? ACCEL_W'(1) : max_accel_q;
    sq    = DIVD_W'(vm) * DIVD_W'(vm);
    if (cmd_i.div_sel == DIV_STOP) begin
      div_dividend = sq;
      div_divisor  = {a_eff, 1'b0};
    end else begin
      div_dividend = DIVD_W'(om) << F;
      div_divisor  = DIVS_W'(tick_q);
    end
  end

  alaa_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quo),
    .done_o     (div_done)
  );

  always_comb begin
    quadp  = QP_W'(ad_q) * QP_W'(tick_q);
    stop_s = vel[ANGLE_W-1] ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    so     = SO_W'(off) - stop_s;

    dv_s = $signed(VS_W'({1'b0, dv_q}));
    if (s_pos_q) begin
      vs = VS_W'(vel) + dv_s;
    end else if (s_neg_q) begin
      vs = VS_W'(vel) - dv_s;
    end else begin
      vs = VS_W'(vel);
    end

    vnm  = vn_q[ANGLE_W-1] ? ANGLE_W'(-vn_q) : ANGLE_W'(vn_q);
    linp = LINP_W'(vnm) * LINP_W'(tick_q);

    lin_s  = vn_q[ANGLE_W-1] ? -$signed(CH_W'({1'b0, lin_q})) : $signed(CH_W'({1'b0, lin_q}));
    if (s_pos_q) begin
      quad_s = $signed(CH_W'({1'b0, quad_q}));
    end else if (s_neg_q) begin
      quad_s = -$signed(CH_W'({1'b0, quad_q}));
    end else begin
      quad_s = '0;
    end

    chm      = ch_q[CH_W-1] ? CH_W'(-ch_q) : CH_W'(ch_q);
    over     = (ch_q != '0) && (ch_q[CH_W-1] == off[OFF_W-1]) && (CMP_W'(chm) > CMP_W'(om));
    off_zero = (off == '0);
    snap     = off_zero || (om < OFF_W'(snap_thr_q)) || over;
    need_div = snap && !off_zero && (tick_q != '0);
    ps       = PS_W'(pos) + PS_W'(ch_q);
    new_pos  = snap ? tgt : sat_angle(SAT_W'(ps));

    if (off_zero) begin
      dec_rate = '0;
    end else if (snap) begin
      dec_rate = off[OFF_W-1] ? ANGLE_MIN : ANGLE_MAX;
    end else begin
      dec_rate = vn_q;
    end

    if (quo[DIVD_W-1:ANGLE_W-1] != '0) begin
      snap_rate = off_neg_q ? ANGLE_MIN : ANGLE_MAX;
    end else begin
      snap_rate = off_neg_q ? -$signed(quo[ANGLE_W-1:0]) : $signed(quo[ANGLE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_accel_q <= MAX_ACCEL_RST;
      tick_q      <= TICK_RST;
      snap_thr_q  <= SNAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_MAX_ACCEL:      max_accel_q <= cfg_data_i[ACCEL_W-1:0];
        CFG_TICK_PERIOD:    tick_q      <= cfg_data_i[TICK_W-1:0];
        CFG_SNAP_THRESHOLD: snap_thr_q  <= cfg_data_i[SNAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < AXES; i++) begin
        angle_q[i] <= '0;
        rate_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.dec) begin
        angle_q[cmd_i.axis] <= new_pos;
        if (!need_div) begin
          rate_q[cmd_i.axis] <= dec_rate;
        end
      end
      if (cmd_i.rate_wr) begin
        rate_q[cmd_i.axis] <= snap_rate;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      tgt_q[0] <= tgt_i.target_x;
      tgt_q[1] <= tgt_i.target_y;
      tgt_q[2] <= tgt_i.target_z;
      ad_q     <= AD_W'(max_accel_q) * AD_W'(tick_q);
    end
    if (cmd_i.prod) begin
      dv_q   <= ad_q[AD_W-1:F];
      quad_q <= quadp[QP_W-1:2*F+1];
    end
    if (cmd_i.dir) begin
      s_pos_q <= !so[SO_W-1] && (so != '0);
      s_neg_q <= so[SO_W-1];
    end
    if (cmd_i.vel) begin
      vn_q <= sat_angle(SAT_W'(vs));
    end
    if (cmd_i.lin) begin
      lin_q <= linp[LINP_W-1:F];
    end
    if (cmd_i.ch) begin
      ch_q <= lin_s + quad_s;
    end
    if (cmd_i.dec) begin
      off_neg_q <= off[OFF_W-1];
    end
    if (cmd_i.res_load) begin
      res_q.angle_x <= angle_q[0];
      res_q.angle_y <= angle_q[1];
      res_q.angle_z <= angle_q[2];
      res_q.rate_x  <= rate_q[0];
      res_q.rate_y  <= rate_q[1];
      res_q.rate_z  <= rate_q[2];
    end
  end

  assign st_o.div_done = div_done;
  assign st_o.need_div = need_div;
  assign res_o         = res_q;

endmodule

>>> rtl/alaa_ctrl.sv
`timescale 1ns / 1ps

module alaa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output alaa_pkg::cmd_t    cmd_o,
  input  alaa_pkg::status_t st_i
);
  import alaa_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE = 11'b000_0000_0001,
    S_PROD = 11'b000_0000_0010,
    S_SQ   = 11'b000_0000_0100,
    S_DIV1 = 11'b000_0000_1000,
    S_DIR  = 11'b000_0001_0000,
    S_VEL  = 11'b000_0010_0000,
    S_LIN  = 11'b000_0100_0000,
    S_CH   = 11'b000_1000_0000,
    S_DEC  = 11'b001_0000_0000,
    S_DIV2 = 11'b010_0000_0000,
    S_OUT  = 11'b100_0000_0000
  } state_e;

  localparam logic [AXIS_W-1:0] AXIS_LAST = AXIS_W'(AXES - 1);

  state_e            state_q, state_d;
  logic [AXIS_W-1:0] axis_q, axis_d;
  logic              out_valid_q, out_valid_d;
  logic              advance;

  always_comb begin
    state_d       = state_q;
    axis_d        = axis_q;
    advance       = 1'b0;
    in_ready_o    = 1'b0;
    cmd_o         = '0;
    cmd_o.div_sel = DIV_STOP;
    cmd_o.axis    = axis_q;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          axis_d     = '0;
          state_d    = S_PROD;
        end
      end
      S_PROD: begin
        cmd_o.prod = 1'b1;
        state_d    = S_SQ;
      end
      S_SQ: begin
        cmd_o.div_start = 1'b1;
        state_d         = S_DIV1;
      end
      S_DIV1: begin
        if (st_i.div_done) begin
          state_d = S_DIR;
        end
      end
      S_DIR: begin
        cmd_o.dir = 1'b1;
        state_d   = S_VEL;
      end
      S_VEL: begin
        cmd_o.vel = 1'b1;
        state_d   = S_LIN;
      end
      S_LIN: begin
        cmd_o.lin = 1'b1;
        state_d   = S_CH;
      end
      S_CH: begin
        cmd_o.ch = 1'b1;
        state_d  = S_DEC;
      end
      S_DEC: begin
        cmd_o.dec = 1'b1;
        if (st_i.need_div) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_SNAP;
          state_d         = S_DIV2;
        end else begin
          advance = 1'b1;
        end
      end
      S_DIV2: begin
        cmd_o.div_sel = DIV_SNAP;
        if (st_i.div_done) begin
          cmd_o.rate_wr = 1'b1;
          advance       = 1'b1;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.res_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (advance) begin
      if (axis_q == AXIS_LAST) begin
        state_d = S_OUT;
      end else begin
        axis_d  = axis_q + AXIS_W'(1);
        state_d = S_SQ;
      end
    end

    if (cmd_o.res_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/accel_limited_angle_approach.sv
`timescale 1ns / 1ps
// Each accepted item steps through the axes in turn: a stop-distance division, then the
// direction, velocity, linear, change and decision steps, and a snap-rate division for each
// axis that snaps to a nonzero offset with a nonzero tick period, both on the 64-step shared
// divider. A new item is taken once the previous one is through, while its result may wait.
// Reset: angles and rates clear to zero, registers load their defaults, no result pending.
module accel_limited_angle_approach #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [alaa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [alaa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  alaa_stream_if.sink                     tgt_i,
  alaa_stream_if.source                   res_o
);
  import alaa_pkg::*;

  cmd_t    cmd;
  status_t st;

  alaa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (tgt_i.valid),
    .in_ready_o  (tgt_i.ready),
    .out_valid_o (res_o.valid),
    .out_ready_i (res_o.ready),
    .cmd_o       (cmd),
    .st_i        (st)
  );

  alaa_datapath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .tgt_i      (tgt_i.payload),
    .cmd_i      (cmd),
    .st_o       (st),
    .res_o      (res_o.payload)
  );

endmodule

>>> tb/sv/alaa_motion_checker.sv
`timescale 1ns / 1ps

module alaa_motion_checker #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [alaa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [alaa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            tgt_valid_i,
  input  logic                            tgt_ready_i,
  input  alaa_pkg::target_t               tgt_data_i,
  input  logic                            res_valid_i,
  input  logic                            res_ready_i,
  input  alaa_pkg::result_t               res_data_i,
  output int                              mismatches_o,
  output int                              pending_o
);
  import alaa_pkg::*;

  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam int     FIELDS  = 6;

  longint      angle_q [AXES];
  longint      rate_q  [AXES];
  logic [63:0] accel_q;
  logic [63:0] tick_q;
  logic [63:0] snap_q;

  result_t     expected_motion [$];
  logic [FIELDS*ANGLE_W-1:0] exp_bits;
  logic [FIELDS*ANGLE_W-1:0] got_bits;
  string       field_names [FIELDS] = '{"angle_x", "angle_y", "angle_z",
                                        "rate_x", "rate_y", "rate_z"};

  function automatic longint sat32(input longint x);
    return (x > S32_MAX) ? S32_MAX : ((x < S32_MIN) ? S32_MIN : x);
  endfunction

  function automatic logic [63:0] mag(input longint x);
    return (x < 0) ? 64'(-x) : 64'(x);
  endfunction

  function automatic void advance_axis(input int k, input longint goal);
    longint      pos, vel, stop, off, shortfall, dv, vn, lin, quad, ch;
    logic [63:0] a, dt, dvsr, vm, stop_m, om, lin_m, rate_m;
    int          s;
    bit          over;
    pos       = angle_q[k];
    vel       = rate_q[k];
    a         = accel_q;
    dt        = tick_q;
    dvsr      = (a != 0) ? (a << 1) : 64'd2;
    vm        = mag(vel);
    stop_m    = (vm * vm) / dvsr;
    stop      = (vel < 0) ? -longint'(stop_m) : longint'(stop_m);
    off       = goal - pos;
    shortfall = off - stop;
    s         = (shortfall > 0) ? 1 : ((shortfall < 0) ? -1 : 0);
    dv        = longint'((a * dt) >> FRACTION_BITS);
    vn        = sat32(vel + longint'(s) * dv);
    lin_m     = (mag(vn) * dt) >> FRACTION_BITS;
    lin       = (vn < 0) ? -longint'(lin_m) : longint'(lin_m);
    quad      = longint'(((a * dt) * dt) >> (2 * FRACTION_BITS + 1));
    ch        = lin + longint'(s) * quad;
    om        = mag(off);
    over      = (ch != 0) && ((ch < 0) == (off < 0)) && (mag(ch) > om);
    if (off == 0 || om < snap_q || over) begin
      angle_q[k] = goal;
      if (off == 0) begin
        rate_q[k] = 0;
      end else if (dt == 0) begin
        rate_q[k] = (off < 0) ? S32_MIN : S32_MAX;
      end else begin
        rate_m    = (om << FRACTION_BITS) / dt;
        rate_q[k] = sat32((off < 0) ? -longint'(rate_m) : longint'(rate_m));
      end
    end else begin
      angle_q[k] = sat32(pos + ch);
      rate_q[k]  = vn;
    end
  endfunction

  function automatic result_t predict_tick(input target_t tgt);
    result_t r;
    advance_axis(0, longint'($signed(tgt.target_x)));
    advance_axis(1, longint'($signed(tgt.target_y)));
    advance_axis(2, longint'($signed(tgt.target_z)));
    r.angle_x = 32'(angle_q[0]);
    r.angle_y = 32'(angle_q[1]);
    r.angle_z = 32'(angle_q[2]);
    r.rate_x  = 32'(rate_q[0]);
    r.rate_y  = 32'(rate_q[1]);
    r.rate_z  = 32'(rate_q[2]);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < AXES; k++) begin
        angle_q[k] = 0;
        rate_q[k]  = 0;
      end
      accel_q = 64'(MAX_ACCEL_RST);
      tick_q  = 64'(TICK_RST);
      snap_q  = 64'(SNAP_RST);
      expected_motion.delete();
      mismatches_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_ACCEL:      accel_q = 64'(cfg_data_i[ACCEL_W-1:0]);
          CFG_TICK_PERIOD:    tick_q  = 64'(cfg_data_i[TICK_W-1:0]);
          CFG_SNAP_THRESHOLD: snap_q  = 64'(cfg_data_i[SNAP_W-1:0]);
          default: ;
        endcase
      end
      if (tgt_valid_i && tgt_ready_i) begin
        expected_motion.push_back(predict_tick(tgt_data_i));
      end
      if (res_valid_i && res_ready_i) begin
        got_bits = res_data_i;
        if (expected_motion.size() == 0) begin
          mismatches_o++;
          $display("%0t: result with nothing pending, expected none actual %h", $time,
                   got_bits);
        end else begin
          exp_bits = expected_motion.pop_front();
          for (int f = 0; f < FIELDS; f++) begin
            if (exp_bits[(FIELDS-1-f)*ANGLE_W +: ANGLE_W] !==
                got_bits[(FIELDS-1-f)*ANGLE_W +: ANGLE_W]) begin
              mismatches_o++;
              $display("%0t: %s mismatch, expected %0d actual %0d", $time, field_names[f],
                       $signed(exp_bits[(FIELDS-1-f)*ANGLE_W +: ANGLE_W]),
                       $signed(got_bits[(FIELDS-1-f)*ANGLE_W +: ANGLE_W]));
            end
          end
        end
      end
      pending_o = expected_motion.size();
    end
  end

endmodule

>>> tb/sv/accel_limited_angle_approach_tb.sv
`timescale 1ns / 1ps

module accel_limited_angle_approach_tb;
  import alaa_pkg::*;

  localparam int unsigned FRACTION_BITS = 16;
  localparam int          PHASES        = 13;
  localparam int          PHASE_ITEMS   = 140;
  localparam int          LONG_HOLD     = 1500;
  localparam int          DRAIN_CYCLES  = 450;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  alaa_stream_if #(.T(target_t)) tgt_if ();
  alaa_stream_if #(.T(result_t)) res_if ();

  int          mismatches;
  int          pending;
  int          idle_pct;
  bit          long_hold_req;
  logic [31:0] aim [AXES];
  int          hold_left;
  bit          noise_run;
  target_t     directed [$];

  accel_limited_angle_approach #(
    .FRACTION_BITS(FRACTION_BITS)
  ) i_dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we),
    .cfg_idx_i (cfg_idx),
    .cfg_data_i(cfg_data),
    .tgt_i     (tgt_if),
    .res_o     (res_if)
  );

  alaa_motion_checker #(
    .FRACTION_BITS(FRACTION_BITS)
  ) i_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data),
    .tgt_valid_i (tgt_if.valid),
    .tgt_ready_i (tgt_if.ready),
    .tgt_data_i  (tgt_if.payload),
    .res_valid_i (res_if.valid),
    .res_ready_i (res_if.ready),
    .res_data_i  (res_if.payload),
    .mismatches_o(mismatches),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(64'd50_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stall bursts, one long hold-off on request
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        res_if.ready  <= 1'b0;
        long_hold_req = 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if ($urandom_range(0, 99) < idle_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk_i);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic write_config(input logic [ACCEL_W-1:0] accel, input logic [TICK_W-1:0] tick,
                              input logic [SNAP_W-1:0] snap);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_MAX_ACCEL;
    cfg_data <= CFG_DATA_W'(accel);
    @(posedge clk_i);
    cfg_idx  <= CFG_TICK_PERIOD;
    cfg_data <= CFG_DATA_W'(tick);
    @(posedge clk_i);
    cfg_idx  <= CFG_SNAP_THRESHOLD;
    cfg_data <= CFG_DATA_W'(snap);
    @(posedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic send_target(input target_t t);
    tgt_if.valid   <= 1'b1;
    tgt_if.payload <= t;
    do @(posedge clk_i); while (!tgt_if.ready);
    if ($urandom_range(0, 99) < idle_pct) begin
      tgt_if.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  // hold a target near the last one for a while so the axes settle, with noise between
  function automatic target_t next_target();
    logic [31:0] pick [AXES];
    longint      jump;
    if (hold_left == 0) begin
      noise_run = ($urandom_range(0, 99) < 15);
      hold_left = noise_run ? 1 : $urandom_range(1, 40);
      if (!noise_run) begin
        for (int k = 0; k < AXES; k++) begin
          jump = longint'($urandom >> $urandom_range(0, 31));
          if ($urandom_range(0, 1) == 1) jump = -jump;
          aim[k] = aim[k] + 32'(jump);
        end
      end
    end
    hold_left--;
    for (int k = 0; k < AXES; k++) begin
      if (noise_run) begin
        case ($urandom_range(0, 5))
          0:       pick[k] = ANGLE_MAX;
          1:       pick[k] = ANGLE_MIN;
          2:       pick[k] = '0;
          default: pick[k] = $urandom;
        endcase
      end else begin
        if ($urandom_range(0, 4) == 0) aim[k] = aim[k] + 32'($urandom_range(0, 32)) - 32'd16;
        pick[k] = aim[k];
      end
    end
    return {pick[0], pick[1], pick[2]};
  endfunction

  initial begin
    tgt_if.valid   <= 1'b0;
    tgt_if.payload <= '0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CFG_MAX_ACCEL;
    cfg_data       <= '0;
    idle_pct       = 0;
    long_hold_req  = 1'b0;
    hold_left      = 0;
    noise_run      = 1'b0;
    for (int k = 0; k < AXES; k++) aim[k] = '0;

    directed.push_back({32'd0, 32'd0, 32'd0});
    directed.push_back({32'd6, -32'sd6, 32'd0});
    directed.push_back({32'd13, -32'sd13, 32'd7});
    directed.push_back({ANGLE_MAX, ANGLE_MIN, 32'd0});
    directed.push_back({ANGLE_MAX, ANGLE_MIN, 32'h0001_0000});
    directed.push_back({ANGLE_MAX, ANGLE_MIN, 32'h0001_0000});
    directed.push_back({ANGLE_MIN, ANGLE_MAX, 32'hffff_0000});
    directed.push_back({ANGLE_MIN, ANGLE_MAX, 32'hffff_0000});
    directed.push_back({32'd0, 32'd0, 32'd0});
    directed.push_back({32'h0000_0001, 32'hffff_ffff, 32'h0001_0000});
    directed.push_back({32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f});
    directed.push_back({32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0});
    directed.push_back({32'd0, 32'd0, 32'd0});
    directed.push_back({32'd0, 32'd0, 32'd0});

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: write_config({ACCEL_W{1'b1}}, {TICK_W{1'b1}}, {SNAP_W{1'b1}});
        2: write_config(ACCEL_W'(1), TICK_W'(1), SNAP_W'(0));
        3: write_config(ACCEL_W'(0), TICK_W'($urandom), SNAP_W'($urandom_range(0, 64)));
        4: write_config(ACCEL_W'($urandom >> $urandom_range(1, 31)), TICK_W'(0),
                        SNAP_W'($urandom_range(0, 64)));
        default: write_config(ACCEL_W'($urandom >> $urandom_range(1, 31)),
                              TICK_W'($urandom_range(1, 65535) >> $urandom_range(0, 12)),
                              SNAP_W'($urandom >> $urandom_range(16, 31)));
      endcase
      idle_pct = (phase == PHASES - 1) ? 0 : 8 * $urandom_range(0, 3);
      if (phase == 0) begin
        foreach (directed[i]) send_target(directed[i]);
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 6 && n == 40) long_hold_req = 1'b1;
        send_target(next_target());
      end
      tgt_if.valid <= 1'b0;
      do @(posedge clk_i); while (pending != 0);
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> accel_limited_angle_approach.f
rtl/alaa_pkg.sv
rtl/alaa_stream_if.sv
rtl/alaa_div.sv
rtl/alaa_datapath.sv
rtl/alaa_ctrl.sv
rtl/accel_limited_angle_approach.sv
tb/sv/alaa_motion_checker.sv
tb/sv/accel_limited_angle_approach_tb.sv
